// ===== sv/etrlbr_pkg.sv =====
// Shared widths and constants for the edge timestamp bit recovery block.
// No dependencies; compile first.
`default_nettype none

package etrlbr_pkg;

  localparam int STAMP_W  = 16;  // timestamp field width
  localparam int PERIOD_W = 16;  // bit period register width
  localparam int FRAME_W  = 21;  // raw frame word width
  localparam int POS_W    = 6;   // bit position counter width
  localparam int RUN_W    = 2;   // run length kept modulo 4
  localparam int DIV_W    = PERIOD_W + 1;  // interval plus half period

  localparam logic [POS_W-1:0]    POS_MAX          = 6'd63;
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd448;

endpackage : etrlbr_pkg

`default_nettype wire

// ===== sv/etrlbr_in_if.sv =====
// Edge channel: valid/ready with one captured edge timestamp and frame marks.
// Depends on etrlbr_pkg.
`default_nettype none

interface etrlbr_in_if;
  import etrlbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] timestamp;
  logic               first_edge;
  logic               last_edge;

  modport source (output valid, output timestamp, output first_edge, output last_edge,
                  input ready);
  modport sink   (input valid, input timestamp, input first_edge, input last_edge,
                  output ready);
endinterface : etrlbr_in_if

`default_nettype wire

// ===== sv/etrlbr_out_if.sv =====
// Frame channel: valid/ready with one recovered raw frame word.
// Depends on etrlbr_pkg.
`default_nettype none

interface etrlbr_out_if;
  import etrlbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] raw_frame;

  modport source (output valid, output raw_frame, input ready);
  modport sink   (input valid, input raw_frame, output ready);
endinterface : etrlbr_out_if

`default_nettype wire

// ===== sv/etrlbr_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, low two bits kept.
// Depends on etrlbr_pkg.
`default_nettype none

module etrlbr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [etrlbr_pkg::DIV_W-1:0]      dividend,
  input  logic [etrlbr_pkg::PERIOD_W-1:0]   divisor,
  output logic                              done,
  output logic [etrlbr_pkg::RUN_W-1:0]      quot_lo
);
  import etrlbr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    count;
  logic [PERIOD_W-1:0] rem;
  logic [DIV_W-1:0]    dvd;
  logic [PERIOD_W-1:0] dsr;
  logic [RUN_W-1:0]    quot;

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                fits;

  assign trial = {rem, dvd[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift one dividend bit into the partial remainder per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd  <= {dvd[DIV_W-2:0], 1'b0};
      quot <= {quot[RUN_W-2:0], fits};
    end
  end

  assign quot_lo = quot;

endmodule : etrlbr_div

`default_nettype wire

// ===== sv/edge_timestamp_run_length_bit_recovery.sv =====
// Edge timestamp run-length bit recovery, top level.
// Sequence: a measured edge (no first mark) is accepted in S_IDLE, divided bit-serially
//   in S_DIVIDE and applied on divider done; a last edge, also a first one, then passes
//   S_FINISH, which loads the output register once it is free.
// Edges are taken only in S_IDLE, so a new edge waits until the previous one is through.
// Reset (rst, synchronous, active high) clears decode state and sets bit_period to 448.
`default_nettype none

module edge_timestamp_run_length_bit_recovery #(
  parameter int LAST_BIT_POSITION = 20,
  parameter int STAMP_BITS        = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  etrlbr_in_if.sink                        edges,
  etrlbr_out_if.source                     frames,
  input  logic                             cfg_wr_en,
  input  logic [etrlbr_pkg::PERIOD_W-1:0]  cfg_wr_data
);
  import etrlbr_pkg::*;

  // Timestamps never carry more than the field width.
  localparam int SW = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t              state;
  logic [PERIOD_W-1:0] bit_period;
  logic [SW-1:0]       previous_stamp;
  logic                line_level;
  logic [POS_W-1:0]    bit_position;
  logic [FRAME_W-1:0]  frame_acc;
  logic                last_pending;
  logic                out_valid;
  logic [FRAME_W-1:0]  out_frame;

  logic                accept;
  logic                div_start;
  logic                div_done;
  logic [RUN_W-1:0]    runs;
  logic [PERIOD_W-1:0] period_eff;
  logic [SW-1:0]       interval;
  logic [DIV_W-1:0]    dividend;
  logic [POS_W:0]      pos_sum;
  logic [FRAME_W-1:0]  run_mask;
  logic [FRAME_W-1:0]  fill_mask;
  logic                out_free;

  // Take a new edge only between items; a full output register stalls only the finishing step.
  assign edges.ready = (state == S_IDLE);
  assign accept      = edges.valid && edges.ready;
  assign div_start   = accept && !edges.first_edge;

  // A zero period behaves as one tick; round to nearest by adding half a period.
  assign period_eff = (bit_period == '0) ? PERIOD_W'(1) : bit_period;
  assign interval   = edges.timestamp[SW-1:0] - previous_stamp;
  assign dividend   = DIV_W'(interval) + DIV_W'(period_eff[PERIOD_W-1:1]);

  etrlbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (period_eff),
    .done     (div_done),
    .quot_lo  (runs)
  );

  // Frame bit i holds position LAST_BIT_POSITION - i; positions past the frame drop out.
  always_comb begin
    for (int i = 0; i < FRAME_W; i++) begin
      run_mask[i]  = (LAST_BIT_POSITION - i >= 0) &&
                     (LAST_BIT_POSITION - i >= int'(bit_position)) &&
                     (LAST_BIT_POSITION - i <  int'(bit_position) + int'(runs));
      fill_mask[i] = (LAST_BIT_POSITION - i >= 0) &&
                     (LAST_BIT_POSITION - i >= int'(bit_position));
    end
  end

  assign pos_sum  = {1'b0, bit_position} + (POS_W + 1)'(runs);
  assign out_free = !out_valid || frames.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bit_period     <= BIT_PERIOD_RESET;
      previous_stamp <= '0;
      line_level     <= 1'b0;
      bit_position   <= '0;
      frame_acc      <= '0;
      last_pending   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bit_period <= cfg_wr_data;
      end

      // Load a finished frame when the register is free; drop the held frame
      // once the sink takes the transfer.
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (frames.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_stamp <= edges.timestamp[SW-1:0];
            last_pending   <= edges.last_edge;
            if (edges.first_edge) begin
              // First edge is only the reference: restart the frame.
              line_level   <= 1'b0;
              bit_position <= '0;
              frame_acc    <= '0;
              state        <= edges.last_edge ? S_FINISH : S_IDLE;
            end else begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            // A high run sets its positions; then flip level and advance.
            if (line_level) begin
              frame_acc <= frame_acc | run_mask;
            end
            line_level   <= !line_level;
            bit_position <= (pos_sum > (POS_W + 1)'(POS_MAX)) ? POS_MAX
                                                                : pos_sum[POS_W-1:0];
            state        <= last_pending ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          // Fill every unreached position with ones; the fill stays in the word.
          if (out_free) begin
            frame_acc <= frame_acc | fill_mask;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register, loaded only when free.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_frame <= frame_acc | fill_mask;
    end
  end

  assign frames.valid     = out_valid;
  assign frames.raw_frame = out_frame;

endmodule : edge_timestamp_run_length_bit_recovery

`default_nettype wire

// ===== sv/etrlbr_chk.sv =====
// Port-level checker for the edge timestamp bit recovery top level, with its bind.
// Depends on etrlbr_pkg and the top level's ports.
`default_nettype none

module etrlbr_chk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_first,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [etrlbr_pkg::FRAME_W-1:0]  out_frame
);
  import etrlbr_pkg::*;

  // Hold a stalled frame transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_frame))
    else $error("frame changed or dropped while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("frame valid after reset");

  // A measured edge keeps the divider busy, so no edge follows at once.
  a_busy_after_edge: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_first |=> !in_ready)
    else $error("edge accepted while interval divide in progress");

  // A new frame appears only right after a state in which no edge could be taken.
  a_frame_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("frame loaded without finishing step");

endmodule : etrlbr_chk

bind edge_timestamp_run_length_bit_recovery etrlbr_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (edges.valid),
  .in_ready  (edges.ready),
  .in_first  (edges.first_edge),
  .out_valid (frames.valid),
  .out_ready (frames.ready),
  .out_frame (frames.raw_frame)
);

`default_nettype wire

// ===== sim/edge_timestamp_run_length_bit_recovery_test.sv =====
// Self-checking bench for the edge timestamp run-length bit recovery block.
// Depends on etrlbr_pkg, etrlbr_in_if, etrlbr_out_if and the block itself.
// Frames are predicted per accepted edge and checked in order on the frame channel.
`default_nettype none

module edge_timestamp_run_length_bit_recovery_test;
  import etrlbr_pkg::*;

  localparam int LAST_POS      = FRAME_W - 1;  // frame position that lands in bit 0
  localparam int SETTLE_CYCLES = 30;           // time for the block to finish an edge that owes no frame
  localparam int STALL_LIMIT   = 4000;         // cycles with no transfer before giving up
  localparam int HOLD_CYCLES   = 600;          // long receiver hold-off for the back-pressure test

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [PERIOD_W-1:0] cfg_wr_data;

  etrlbr_in_if  edges_if ();
  etrlbr_out_if frames_if ();

  edge_timestamp_run_length_bit_recovery uut (
    .clk        (clk),
    .rst        (rst),
    .edges      (edges_if),
    .frames     (frames_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Decoder state as the block should hold it, plus the frames still owed.
  logic [PERIOD_W-1:0] period_q     = BIT_PERIOD_RESET;
  logic [STAMP_W-1:0]  prev_stamp_q = '0;
  logic                level_q      = 1'b0;
  logic [POS_W-1:0]    pos_q        = '0;
  logic [FRAME_W-1:0]  word_q       = '0;
  logic [FRAME_W-1:0]  pending_frames[$];
  logic [FRAME_W-1:0]  exp_frame;

  int                  mismatches   = 0;
  int                  idle_cycles  = 0;
  int                  hold_frames  = 0;   // receiver hold-off, counted down by the sink
  bit                  steady       = 1'b0; // suppress random gaps on both channels
  logic [STAMP_W-1:0]  stamp_now;           // timestamp of the last accepted edge

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Set one frame position; positions past the last bit fall off the word.
  function automatic void set_frame_bit(input int position);
    if (position <= LAST_POS) begin
      word_q[LAST_POS - position] = 1'b1;
    end
  endfunction

  // Advance the decoder by one accepted edge and queue a frame on a last edge.
  function automatic void recover_edge(input logic [STAMP_W-1:0] stamp, input bit is_first,
                                       input bit is_last);
    int unsigned        divisor;
    int unsigned        runs;
    logic [STAMP_W-1:0] interval;
    int                 k;
    int                 next_pos;

    if (is_first) begin
      // A first edge only sets the reference; no interval is measured.
      prev_stamp_q = stamp;
      level_q      = 1'b0;
      pos_q        = '0;
      word_q       = '0;
    end else begin
      divisor  = (period_q == 0) ? 1 : period_q;
      interval = stamp - prev_stamp_q;  // wraps modulo the stamp width
      runs     = ((interval + divisor / 2) / divisor) % 4;
      prev_stamp_q = stamp;
      // Only a high run marks its positions as ones.
      if (level_q) begin
        for (k = 0; k < runs; k++) begin
          set_frame_bit(pos_q + k);
        end
      end
      level_q  = ~level_q;
      next_pos = pos_q + runs;
      pos_q    = (next_pos > POS_MAX) ? POS_MAX : next_pos[POS_W-1:0];
    end

    if (is_last) begin
      // Fill every position not yet reached with ones, then emit the word.
      for (k = pos_q; k <= LAST_POS; k++) begin
        set_frame_bit(k);
      end
      pending_frames.push_back(word_q);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Compare each frame transfer with the oldest owed frame.
  always @(posedge clk) begin
    if (!rst && frames_if.valid === 1'b1 && frames_if.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("raw_frame %06h with no frame pending", frames_if.raw_frame));
      end else begin
        exp_frame = pending_frames.pop_front();
        if (frames_if.raw_frame !== exp_frame) begin
          report_mismatch($sformatf("raw_frame got %06h expected %06h",
                                    frames_if.raw_frame, exp_frame));
        end
      end
    end
  end

  // Count cycles without any transfer; stop a hung run.
  always @(posedge clk) begin
    if ((edges_if.valid === 1'b1 && edges_if.ready === 1'b1) ||
        (frames_if.valid === 1'b1 && frames_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Frame receiver: random stalls, plus the long hold-off when one is requested.
  initial begin : frame_sink
    int stall_left;
    stall_left      = 0;
    frames_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_frames > 0) begin
        frames_if.ready = 1'b0;
        hold_frames--;
      end else if (stall_left > 0) begin
        frames_if.ready = 1'b0;
        stall_left--;
      end else begin
        stall_left      = pick_gap();
        frames_if.ready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Offer one edge, hold it until the transfer, then predict from it.
  // Valid stays high after the transfer; the next drive decides what follows.
  task automatic send_edge(input logic [STAMP_W-1:0] stamp, input bit is_first,
                           input bit is_last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      edges_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    edges_if.valid      = 1'b1;
    edges_if.timestamp  = stamp;
    edges_if.first_edge = is_first;
    edges_if.last_edge  = is_last;
    do @(posedge clk); while (edges_if.ready !== 1'b1);
    recover_edge(stamp, is_first, is_last);
    stamp_now = stamp;
  endtask

  // Drop valid, wait for every owed frame, then let the block finish any
  // edge that produces no frame.
  task automatic drain_frames();
    @(negedge clk);
    edges_if.valid = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bit period; call only with the block drained.
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    period_q    = value;
  endtask

  // Well-formed frame: first edge, then edges spaced by whole bit periods
  // with jitter of at most half a period, the final one marked last.
  task automatic send_frame(input int n_edges, input int max_runs);
    int per;
    int k;
    int runs;
    int jitter;
    per = (period_q == 0) ? 1 : period_q;
    send_edge(STAMP_W'($urandom), 1'b1, n_edges == 0);
    for (k = 1; k <= n_edges; k++) begin
      runs   = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(0, max_runs);
      jitter = int'($urandom_range(0, per - 1)) - (per - 1) / 2;
      send_edge(STAMP_W'(int'(stamp_now) + runs * per + jitter), 1'b0, k == n_edges);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edges straight after reset decode from stamp 0, level low, position 0.
  task automatic test_no_first_after_reset();
    send_edge(16'd896, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b1);
  endtask

  // First and last on one edge give all ones.
  task automatic test_first_and_last();
    send_edge(16'h1234, 1'b1, 1'b1);
    send_edge(16'h0000, 1'b1, 1'b1);
  endtask

  // Frame across the stamp wrap, with a four-period run (counts as none)
  // and intervals just on either side of half a period.
  task automatic test_wrapping_frame();
    send_edge(16'hFE00, 1'b1, 1'b0);
    send_edge(STAMP_W'(stamp_now + BIT_PERIOD_RESET), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + 2 * BIT_PERIOD_RESET), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + 3 * BIT_PERIOD_RESET), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + 4 * BIT_PERIOD_RESET), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + BIT_PERIOD_RESET / 2), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + BIT_PERIOD_RESET / 2 - 1), 1'b0, 1'b0);
    send_edge(STAMP_W'(stamp_now + 3 * BIT_PERIOD_RESET), 1'b0, 1'b1);
  endtask

  // A zero bit period divides as one.
  task automatic test_zero_period();
    drain_frames();
    write_period('0);
    send_edge(16'd5, 1'b1, 1'b0);
    send_edge(16'd8, 1'b0, 1'b0);
    send_edge(16'd9, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b1);
  endtask

  // Widest period: a full-period interval, then intervals around half a period.
  task automatic test_widest_period();
    drain_frames();
    write_period(16'hFFFF);
    send_edge(16'h0000, 1'b1, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b0);
    send_edge(16'h7FFE, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b1);
  endtask

  // Without a new first edge the old word keeps growing.
  task automatic test_after_last_edge();
    send_edge(STAMP_W'(stamp_now + 16'h8000), 1'b0, 1'b0);
    send_edge(16'h0000, 1'b0, 1'b1);
  endtask

  // Random phase at one bit period: mostly well-formed frames (some long
  // enough to saturate the position), the rest noise and headless runs.
  task automatic test_random_frames(input logic [PERIOD_W-1:0] period, input int n_items,
                                    input bit quiet);
    int sent;
    int r;
    int n;
    int k;
    drain_frames();
    write_period(period);
    steady = quiet;
    sent   = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = (r < 8) ? $urandom_range(21, 34) : $urandom_range(0, 22);
        send_frame(n, (r < 8) ? 3 : 5);
        sent += n + 1;
      end else if (r < 92) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          send_edge(STAMP_W'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 2) == 0);
        end
        sent += n;
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          send_edge(STAMP_W'(stamp_now + $urandom_range(0, 65535)), 1'b0, k == n - 1);
        end
        sent += n;
      end
    end
    steady = 1'b0;
  endtask

  // Hold the receiver off while edges keep coming so the block backs up
  // into its input.
  task automatic test_output_backpressure();
    int sent;
    int n;
    drain_frames();
    write_period(BIT_PERIOD_RESET);
    steady      = 1'b1;
    hold_frames = HOLD_CYCLES;
    sent        = 0;
    while (sent < 30) begin
      n = $urandom_range(0, 2);
      send_frame(n, 3);
      sent += n + 1;
    end
    steady = 1'b0;
    drain_frames();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    edges_if.valid      = 1'b0;
    edges_if.timestamp  = '0;
    edges_if.first_edge = 1'b0;
    edges_if.last_edge  = 1'b0;
    stamp_now           = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_no_first_after_reset();
    test_first_and_last();
    test_wrapping_frame();
    test_zero_period();
    test_widest_period();
    test_after_last_edge();

    test_random_frames(BIT_PERIOD_RESET, 140, 1'b0);
    test_random_frames(16'd1, 140, 1'b0);
    test_random_frames(16'hFFFF, 140, 1'b1);
    test_random_frames(16'd2, 140, 1'b0);
    test_output_backpressure();
    test_random_frames(PERIOD_W'($urandom_range(3, 4000)), 140, 1'b0);
    test_random_frames(BIT_PERIOD_RESET, 140, 1'b0);

    drain_frames();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : edge_timestamp_run_length_bit_recovery_test

`default_nettype wire
